@@ sv/pixel_point_transform_assert.svh @@
// Assertion macros shared by the pixel point transform checker.
// No dependencies; expects signals named clock and reset in the using scope.
`ifndef PIXEL_POINT_TRANSFORM_ASSERT_SVH
`define PIXEL_POINT_TRANSFORM_ASSERT_SVH

// Concurrent check, masked while reset is high.
`define PPT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also runs across reset.
`define PPT_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/ppt_pkg.sv @@
// Package for the pixel point transform: field widths, register indexes,
// reset values and the mode codes. No dependencies.
`default_nettype none

package ppt_pkg;

   localparam int unsigned PIXEL_WIDTH     = 8;
   localparam int unsigned KNEE_WIDTH      = 7;
   localparam int unsigned MODE_WIDTH      = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 7;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_PASS     = 2'd0,
      MODE_NEGATIVE = 2'd1,
      MODE_BRIGHT   = 2'd2,
      MODE_CONTRAST = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODE     = 2'd0,
      CSR_KNEE_IN  = 2'd1,
      CSR_KNEE_OUT = 2'd2,
      CSR_SPARE    = 2'd3
   } csr_index_type;

   localparam mode_type              MODE_RESET     = MODE_PASS;
   localparam logic [KNEE_WIDTH-1:0] KNEE_IN_RESET  = 7'd110;
   localparam logic [KNEE_WIDTH-1:0] KNEE_OUT_RESET = 7'd70;
   localparam logic [PIXEL_WIDTH-1:0] PIXEL_SAT     = 8'd255;

endpackage

`default_nettype wire

@@ sv/ppt_seg_stage.sv @@
// Entry stage: picks the curve segment for a pixel, forms numerator, divisor
// and offset, and registers them. Depends on ppt_pkg.
`default_nettype none

module ppt_seg_stage #(
   parameter int unsigned PIXEL_MAX = 255
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic [ppt_pkg::PIXEL_WIDTH-1:0]     in_pixel,
   input  wire ppt_pkg::mode_type                   mode,
   input  wire logic [ppt_pkg::KNEE_WIDTH-1:0]      knee_in,
   input  wire logic [ppt_pkg::KNEE_WIDTH-1:0]      knee_out,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic [2*$clog2(PIXEL_MAX+1)-1:0]         out_rem,
   output logic [2*$clog2(PIXEL_MAX+1)-2:0]         out_dsh,
   output logic [$clog2(PIXEL_MAX+1)-1:0]           out_ofs
);

   localparam int unsigned W = $clog2(PIXEL_MAX + 1);
   localparam logic [W-1:0] P_W = W'(PIXEL_MAX);

   logic [W-1:0]                        x_w;
   logic [W-1:0]                        b_w;
   logic [W-1:0]                        a_w;
   logic                                seg_low;
   logic                                seg_mid;
   logic [W-1:0]                        coef;
   logic [ppt_pkg::PIXEL_WIDTH-1:0]     delta;
   logic [W-1:0]                        divisor;
   logic [W-1:0]                        offset;
   logic [2*W-1:0]                      product;

   logic                                valid_ff;
   logic [2*W-1:0]                      rem_ff;
   logic [2*W-2:0]                      dsh_ff;
   logic [W-1:0]                        ofs_ff;

   // A zero knee is treated as one so no divisor is ever zero.
   assign b_w = (knee_in == '0) ? W'(1) : W'(knee_in);
   assign a_w = W'(knee_out);
   assign x_w = W'(in_pixel);

   assign seg_low = (x_w <= b_w);
   assign seg_mid = (x_w <= (P_W - b_w));

   always_comb begin
      coef    = '0;
      delta   = '0;
      divisor = W'(1);
      offset  = x_w;
      unique case (mode)
         ppt_pkg::MODE_PASS: begin
            offset = x_w;
         end
         ppt_pkg::MODE_NEGATIVE: begin
            offset = P_W - x_w;
         end
         ppt_pkg::MODE_BRIGHT: begin
            priority if (seg_low) begin
               coef    = a_w;
               delta   = in_pixel;
               divisor = b_w;
               offset  = '0;
            end else if (seg_mid) begin
               coef    = P_W - (a_w << 1);
               delta   = ppt_pkg::PIXEL_WIDTH'(x_w - b_w);
               divisor = P_W - (b_w << 1);
               offset  = a_w;
            end else begin
               coef    = a_w;
               delta   = ppt_pkg::PIXEL_WIDTH'(x_w - (P_W - b_w));
               divisor = b_w;
               offset  = P_W - a_w;
            end
         end
         ppt_pkg::MODE_CONTRAST: begin
            priority if (seg_low) begin
               coef    = a_w;
               delta   = in_pixel;
               divisor = b_w;
               offset  = '0;
            end else begin
               coef    = P_W - a_w;
               delta   = ppt_pkg::PIXEL_WIDTH'(x_w - b_w);
               divisor = P_W - b_w;
               offset  = a_w;
            end
         end
      endcase
   end

   assign product = (2*W)'(coef) * (2*W)'(delta);

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         rem_ff <= product;
         dsh_ff <= (2*W-1)'(divisor) << (W - 1);
         ofs_ff <= offset;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dsh   = dsh_ff;
   assign out_ofs   = ofs_ff;

endmodule

`default_nettype wire

@@ sv/ppt_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit, MSB first, and
// hands the partial remainder and halved divisor to the next cell. Uses no package.
`default_nettype none

module ppt_div_cell #(
   parameter int unsigned W = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [2*W-1:0]  in_rem,
   input  wire logic [2*W-2:0]  in_dsh,
   input  wire logic [W-1:0]    in_quo,
   input  wire logic [W-1:0]    in_ofs,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output logic [2*W-1:0]       out_rem,
   output logic [2*W-2:0]       out_dsh,
   output logic [W-1:0]         out_quo,
   output logic [W-1:0]         out_ofs
);

   logic             fits;
   logic [2*W-1:0]   rem_in;

   logic             valid_ff;
   logic [2*W-1:0]   rem_ff;
   logic [2*W-2:0]   dsh_ff;
   logic [W-1:0]     quo_ff;
   logic [W-1:0]     ofs_ff;

   assign fits   = (in_rem >= {1'b0, in_dsh});
   assign rem_in = fits ? (in_rem - {1'b0, in_dsh}) : in_rem;

   // Advance when this cell is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         rem_ff <= rem_in;
         dsh_ff <= in_dsh >> 1;
         quo_ff <= {in_quo[W-2:0], fits};
         ofs_ff <= in_ofs;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dsh   = dsh_ff;
   assign out_quo   = quo_ff;
   assign out_ofs   = ofs_ff;

endmodule

`default_nettype wire

@@ sv/pixel_point_transform.sv @@
// Pixel point transform top level: configuration registers, entry stage,
// division cell chain and output register. Depends on ppt_pkg, ppt_seg_stage, ppt_div_cell.
//
// Maps each 8-bit pixel through one of four curves chosen by the mode
// register: pass-through, negative, three-segment brightness, two-segment
// contrast. Knee input and output levels come from the csr_* write port, to be
// written by the user only while no pixel is in flight; the block does not enforce it.
// Pixels enter on req_valid/req_ready and leave on rsp_valid/rsp_ready; one
// result transfer per request transfer, in order.
// A pixel passes through the entry stage (segment select and multiply), the
// division cells (one quotient bit each) and the output register (offset add,
// clamp).
// Throughput: one pixel per clock while the receiver takes results.
// When the receiver stalls, the result holds and pixels keep entering until
// every stage holds one; req_ready then drops.
// Reset empties the pipeline and loads mode 0, knee_in 110, knee_out 70.
`default_nettype none

module pixel_point_transform #(
   parameter int unsigned PIXEL_MAX = 255
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [ppt_pkg::PIXEL_WIDTH-1:0]       req_pixel_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [ppt_pkg::PIXEL_WIDTH-1:0]            rsp_pixel_out,
   input  wire logic                                  csr_we,
   input  wire logic [ppt_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [ppt_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int unsigned W = $clog2(PIXEL_MAX + 1);

   ppt_pkg::mode_type                  mode_ff;
   logic [ppt_pkg::KNEE_WIDTH-1:0]     knee_in_ff;
   logic [ppt_pkg::KNEE_WIDTH-1:0]     knee_out_ff;

   logic                               valid_chain [0:W];
   logic                               ready_chain [0:W];
   logic [2*W-1:0]                     rem_chain   [0:W-1];
   logic [2*W-2:0]                     dsh_chain   [0:W-1];
   logic [W-1:0]                       quo_chain   [0:W];
   logic [W-1:0]                       ofs_chain   [0:W];

   logic [W:0]                         sum;
   logic [ppt_pkg::PIXEL_WIDTH-1:0]    pixel_out_in;
   logic                               rsp_valid_ff;
   logic [ppt_pkg::PIXEL_WIDTH-1:0]    rsp_pixel_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ppt_pkg::MODE_RESET;
         knee_in_ff  <= ppt_pkg::KNEE_IN_RESET;
         knee_out_ff <= ppt_pkg::KNEE_OUT_RESET;
      end else if (csr_we) begin
         unique case (ppt_pkg::csr_index_type'(csr_index))
            ppt_pkg::CSR_MODE:     mode_ff     <= ppt_pkg::mode_type'(
                                                     csr_wdata[ppt_pkg::MODE_WIDTH-1:0]);
            ppt_pkg::CSR_KNEE_IN:  knee_in_ff  <= csr_wdata[ppt_pkg::KNEE_WIDTH-1:0];
            ppt_pkg::CSR_KNEE_OUT: knee_out_ff <= csr_wdata[ppt_pkg::KNEE_WIDTH-1:0];
            ppt_pkg::CSR_SPARE: begin
               // drop writes to the unused index
            end
         endcase
      end
   end

   ppt_seg_stage #(
      .PIXEL_MAX (PIXEL_MAX)
   ) u_seg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pixel  (req_pixel_in),
      .mode      (mode_ff),
      .knee_in   (knee_in_ff),
      .knee_out  (knee_out_ff),
      .out_valid (valid_chain[0]),
      .out_ready (ready_chain[0]),
      .out_rem   (rem_chain[0]),
      .out_dsh   (dsh_chain[0]),
      .out_ofs   (ofs_chain[0])
   );

   assign quo_chain[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_cell
      if (i < W - 1) begin : g_mid
         ppt_div_cell #(
            .W (W)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_rem    (rem_chain[i]),
            .in_dsh    (dsh_chain[i]),
            .in_quo    (quo_chain[i]),
            .in_ofs    (ofs_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_ready (ready_chain[i+1]),
            .out_rem   (rem_chain[i+1]),
            .out_dsh   (dsh_chain[i+1]),
            .out_quo   (quo_chain[i+1]),
            .out_ofs   (ofs_chain[i+1])
         );
      end else begin : g_last
         // the final remainder and divisor are not needed
         ppt_div_cell #(
            .W (W)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_rem    (rem_chain[i]),
            .in_dsh    (dsh_chain[i]),
            .in_quo    (quo_chain[i]),
            .in_ofs    (ofs_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_ready (ready_chain[i+1]),
            .out_rem   (),
            .out_dsh   (),
            .out_quo   (quo_chain[i+1]),
            .out_ofs   (ofs_chain[i+1])
         );
      end
   end

   assign ready_chain[W] = !rsp_valid_ff || rsp_ready;

   // Add the segment offset and clamp to the 8-bit range.
   assign sum          = (W+1)'(quo_chain[W]) + (W+1)'(ofs_chain[W]);
   assign pixel_out_in = (sum > (W+1)'(ppt_pkg::PIXEL_SAT)) ? ppt_pkg::PIXEL_SAT
                                                            : sum[ppt_pkg::PIXEL_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready_chain[W]) begin
         rsp_valid_ff <= valid_chain[W];
      end
      if (valid_chain[W] && ready_chain[W]) begin
         rsp_pixel_out_ff <= pixel_out_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_out_ff;

endmodule

`default_nettype wire

@@ sv/ppt_checker.sv @@
// Port-level checker for the pixel point transform, bound to the top level.
// Depends on pixel_point_transform_assert.svh and pixel_point_transform.
`default_nettype none

`include "pixel_point_transform_assert.svh"

module ppt_checker #(
   parameter int unsigned PIXEL_MAX = 255
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_pixel_out
);

   // Sampled edges from an input transfer to the first edge that sees rsp_valid.
   localparam int unsigned FLOW_DEPTH = $clog2(PIXEL_MAX + 1) + 2;

   `PPT_ASSERT_RST(a_reset_empty, reset |=> (!rsp_valid && req_ready), "pipeline not empty after reset")

   `PPT_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_out)), "result changed while stalled")

   `PPT_ASSERT(a_ready_free, (!rsp_valid || rsp_ready) |-> req_ready, "input blocked with free output")

   `PPT_ASSERT(a_rise_latency, $rose(rsp_valid) |-> $past(req_valid && req_ready, FLOW_DEPTH), "result without matching transfer")

endmodule

bind pixel_point_transform ppt_checker #(.PIXEL_MAX(PIXEL_MAX)) u_ppt_checker (.*);

`default_nettype wire

@@ verif/pixel_point_transform_tb.sv @@
// Self-checking testbench for pixel_point_transform: valid/ready stimulus, csr setup
// and a scoreboard class that predicts each output pixel. Depends on ppt_pkg and the RTL.
`default_nettype none

module pixel_point_transform_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PIXEL_MAX        = 255;
   localparam int unsigned LATENCY          = $clog2(PIXEL_MAX + 1) + 1;
   localparam int unsigned HOLD_OFF_CYCLES  = 80;
   localparam int unsigned RANDOM_PHASES    = 14;
   localparam int unsigned PIXELS_PER_PHASE = 100;

   // Mirror of the csr state plus the queue of pixels still owed by the block.
   class pixel_map_checker_type;
      ppt_pkg::mode_type                  mode;
      logic [ppt_pkg::KNEE_WIDTH-1:0]     knee_in;
      logic [ppt_pkg::KNEE_WIDTH-1:0]     knee_out;
      logic [ppt_pkg::PIXEL_WIDTH-1:0]    expected_pixels[$];
      bit                                 failed;

      function new();
         mode     = ppt_pkg::MODE_RESET;
         knee_in  = ppt_pkg::KNEE_IN_RESET;
         knee_out = ppt_pkg::KNEE_OUT_RESET;
         failed   = 1'b0;
      endfunction

      function void write_reg(ppt_pkg::csr_index_type idx,
                              logic [ppt_pkg::CSR_DATA_WIDTH-1:0] data);
         case (idx)
            ppt_pkg::CSR_MODE:
               mode = ppt_pkg::mode_type'(data[ppt_pkg::MODE_WIDTH-1:0]);
            ppt_pkg::CSR_KNEE_IN:  knee_in = data[ppt_pkg::KNEE_WIDTH-1:0];
            ppt_pkg::CSR_KNEE_OUT: knee_out = data[ppt_pkg::KNEE_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function logic [ppt_pkg::PIXEL_WIDTH-1:0] mapped_pixel(
            logic [ppt_pkg::PIXEL_WIDTH-1:0] pix);
         int unsigned x, b, a, y;
         x = pix;
         // a zero knee behaves as one
         b = (knee_in == 0) ? 1 : knee_in;
         a = knee_out;
         case (mode)
            ppt_pkg::MODE_NEGATIVE: y = PIXEL_MAX - x;
            ppt_pkg::MODE_BRIGHT: begin
               if (x <= b)
                  y = (a * x) / b;
               else if (x <= PIXEL_MAX - b)
                  y = ((PIXEL_MAX - 2 * a) * (x - b)) / (PIXEL_MAX - 2 * b) + a;
               else
                  y = (a * (x - (PIXEL_MAX - b))) / b + (PIXEL_MAX - a);
            end
            ppt_pkg::MODE_CONTRAST: begin
               if (x <= b)
                  y = (a * x) / b;
               else
                  y = ((PIXEL_MAX - a) * (x - b)) / (PIXEL_MAX - b) + a;
            end
            default: y = x;
         endcase
         if (y > ppt_pkg::PIXEL_SAT)
            y = ppt_pkg::PIXEL_SAT;
         return y[ppt_pkg::PIXEL_WIDTH-1:0];
      endfunction

      function void note_pixel(logic [ppt_pkg::PIXEL_WIDTH-1:0] pix);
         expected_pixels.push_back(mapped_pixel(pix));
      endfunction

      function void check_pixel(logic [ppt_pkg::PIXEL_WIDTH-1:0] got);
         logic [ppt_pkg::PIXEL_WIDTH-1:0] want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: pixel_out expected none, got %0d", $time, got);
            failed = 1'b1;
            return;
         end
         want = expected_pixels.pop_front();
         if (got !== want) begin
            $display("%0t: pixel_out expected %0d, got %0d", $time, want, got);
            failed = 1'b1;
         end
      endfunction

      function int outstanding();
         return expected_pixels.size();
      endfunction
   endclass

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic [ppt_pkg::PIXEL_WIDTH-1:0]        req_pixel_in = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic [ppt_pkg::PIXEL_WIDTH-1:0]        rsp_pixel_out;
   logic                                   csr_we = 1'b0;
   logic [ppt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index = '0;
   logic [ppt_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata = '0;

   bit req_gaps = 1'b1;
   bit rsp_stalls = 1'b1;
   bit hold_off_pending = 1'b0;

   pixel_map_checker_type map_check = new();

   pixel_point_transform #(
      .PIXEL_MAX(PIXEL_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_out(rsp_pixel_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Write all three registers back to back, optionally the unused index too.
   task automatic apply_config(input logic [ppt_pkg::CSR_DATA_WIDTH-1:0] mode_word,
                               input logic [ppt_pkg::CSR_DATA_WIDTH-1:0] kin,
                               input logic [ppt_pkg::CSR_DATA_WIDTH-1:0] kout,
                               input bit touch_spare);
      logic [ppt_pkg::CSR_DATA_WIDTH-1:0] junk;
      junk = ppt_pkg::CSR_DATA_WIDTH'($urandom);
      csr_we <= 1'b1;
      csr_index <= ppt_pkg::CSR_MODE;
      csr_wdata <= mode_word;
      @(posedge clock);
      map_check.write_reg(ppt_pkg::CSR_MODE, mode_word);
      csr_index <= ppt_pkg::CSR_KNEE_IN;
      csr_wdata <= kin;
      @(posedge clock);
      map_check.write_reg(ppt_pkg::CSR_KNEE_IN, kin);
      csr_index <= ppt_pkg::CSR_KNEE_OUT;
      csr_wdata <= kout;
      @(posedge clock);
      map_check.write_reg(ppt_pkg::CSR_KNEE_OUT, kout);
      if (touch_spare) begin
         csr_index <= ppt_pkg::CSR_SPARE;
         csr_wdata <= junk;
         @(posedge clock);
         map_check.write_reg(ppt_pkg::CSR_SPARE, junk);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(input logic [ppt_pkg::PIXEL_WIDTH-1:0] pix);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      map_check.note_pixel(pix);
   endtask

   // Drop valid and hold until every owed pixel is back.
   task automatic drain();
      req_valid <= 1'b0;
      while (map_check.outstanding() != 0)
         @(posedge clock);
   endtask

   // Bias toward the knees of the current curve and the range ends.
   function automatic logic [ppt_pkg::PIXEL_WIDTH-1:0] pick_pixel();
      int b, v;
      b = (map_check.knee_in == 0) ? 1 : map_check.knee_in;
      case ($urandom_range(0, 9))
         5, 6:    v = b + $urandom_range(0, 4) - 2;
         7, 8:    v = PIXEL_MAX - b + $urandom_range(0, 4) - 2;
         9:       v = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(253, 255);
         default: v = $urandom_range(0, 255);
      endcase
      if (v < 0)
         v = 0;
      if (v > 255)
         v = 255;
      return ppt_pkg::PIXEL_WIDTH'(v);
   endfunction

   // Result side: ready bursts, random stalls and one long hold-off on request.
   initial begin
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (rsp_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         map_check.check_pixel(rsp_pixel_out);
   end

   initial begin
      logic [ppt_pkg::CSR_DATA_WIDTH-1:0] mode_word, kin, kout;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: pass-through
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'h55);
      send_pixel(8'hAA);
      drain();
      // negative, with the unused mode bits set
      apply_config({5'b11111, ppt_pkg::MODE_NEGATIVE}, 7'd110, 7'd70, 1'b0);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd1);
      drain();
      apply_config({5'b00000, ppt_pkg::MODE_BRIGHT}, 7'd127, 7'd127, 1'b0);
      send_pixel(8'd0);
      send_pixel(8'd127);
      send_pixel(8'd128);
      send_pixel(8'd255);
      drain();
      apply_config({5'b10101, ppt_pkg::MODE_BRIGHT}, 7'd1, 7'd0, 1'b0);
      send_pixel(8'd0);
      send_pixel(8'd1);
      send_pixel(8'd2);
      send_pixel(8'd254);
      send_pixel(8'd255);
      drain();
      // zero knee
      apply_config({5'b01010, ppt_pkg::MODE_CONTRAST}, 7'd0, 7'd127, 1'b0);
      send_pixel(8'd0);
      send_pixel(8'd1);
      send_pixel(8'd2);
      send_pixel(8'd255);
      drain();
      apply_config({5'b00000, ppt_pkg::MODE_CONTRAST}, 7'd127, 7'd0, 1'b1);
      send_pixel(8'd127);
      send_pixel(8'd128);
      send_pixel(8'd255);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode_word = {5'($urandom), ppt_pkg::mode_type'(phase % 4)};
         case ($urandom_range(0, 5))
            0:       kin = 7'd0;
            1:       kin = 7'd1;
            2:       kin = 7'd127;
            default: kin = 7'($urandom_range(1, 127));
         endcase
         case ($urandom_range(0, 5))
            0:       kout = 7'd0;
            1:       kout = 7'd127;
            default: kout = 7'($urandom_range(0, 127));
         endcase
         apply_config(mode_word, kin, kout, 1'b0);
         // keep offering during the long hold-off so the pipeline backs up
         req_gaps = (phase < RANDOM_PHASES - 3) && (phase != 3);
         rsp_stalls = phase < RANDOM_PHASES - 3;
         if (phase == 3)
            hold_off_pending = 1'b1;
         repeat (PIXELS_PER_PHASE) send_pixel(pick_pixel());
         drain();
      end

      repeat (LATENCY + 2) @(posedge clock);
      if (!map_check.failed && map_check.outstanding() == 0)
         $display("pixel_point_transform: match");
      else
         $display("pixel_point_transform: mismatch");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("pixel_point_transform: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
